@@ hdl/mstg_pkg.sv @@
// Shared constants, types and the quarter-wave sine table of the tone generator.
package mstg_pkg;

   localparam int PHASE_BITS      = 32;
   localparam int SINE_INDEX_BITS = 10;
   localparam int SAMPLE_BITS     = 16;
   localparam int COUNT_BITS      = 24;

   localparam int FRAC_BITS      = SAMPLE_BITS - 1;
   localparam int SHAPE_BITS     = 2;
   localparam int STEP_BITS      = 32;
   localparam int PEAK_BITS      = 16;
   localparam int LENGTH_BITS    = 24;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 32;

   localparam int QTR_SIZE      = 1 << SINE_INDEX_BITS;
   localparam int QTR_HALF      = QTR_SIZE / 2;
   localparam int ROM_ADDR_BITS = SINE_INDEX_BITS + 1;
   localparam int SINE_TOP_BITS = SINE_INDEX_BITS + 2;
   localparam int TRI_BITS      = SAMPLE_BITS + 1;
   localparam int PTOP_BITS     = (TRI_BITS > SINE_TOP_BITS) ? TRI_BITS : SINE_TOP_BITS;
   localparam int LEN_CMP_BITS  = (LENGTH_BITS > COUNT_BITS) ? LENGTH_BITS : COUNT_BITS;
   localparam int PROD_BITS     = SAMPLE_BITS + PEAK_BITS;
   localparam int MAG_BITS      = PROD_BITS - FRAC_BITS;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = QPTR_BITS + 1;

   localparam logic [COUNT_BITS-1:0]  COUNT_MAX = '1;
   localparam logic [SAMPLE_BITS-1:0] WAVE_ONE  = SAMPLE_BITS'(1) << FRAC_BITS;
   localparam logic [SAMPLE_BITS-1:0] SAT_POS   = WAVE_ONE - SAMPLE_BITS'(1);
   localparam logic [TRI_BITS-1:0]    TRI_ONE   = TRI_BITS'(1) << FRAC_BITS;
   localparam logic [TRI_BITS-1:0]    TRI_THREE = TRI_BITS'(3) << FRAC_BITS;

   localparam logic [STEP_BITS-1:0]   RESET_PHASE_STEP  = 32'd42852281;
   localparam logic [PEAK_BITS-1:0]   RESET_PEAK_LEVEL  = 16'd9830;
   localparam logic [LENGTH_BITS-1:0] RESET_TONE_LENGTH = 24'd44100;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [9:0]  TAYLOR_DIV [1:10] = '{10'd6, 10'd20, 10'd42, 10'd72, 10'd110,
                                                10'd156, 10'd210, 10'd272, 10'd342, 10'd420};

   typedef enum logic [SHAPE_BITS-1:0] {
      SHAPE_SINE     = 2'd0,
      SHAPE_TRIANGLE = 2'd1,
      SHAPE_SAWTOOTH = 2'd2,
      SHAPE_SQUARE   = 2'd3
   } shape_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_WAVE_SHAPE  = 2'd0,
      CSR_PHASE_STEP  = 2'd1,
      CSR_PEAK_LEVEL  = 2'd2,
      CSR_TONE_LENGTH = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic [PTOP_BITS-1:0] ptop;
      shape_type            shape;
      logic [PEAK_BITS-1:0] peak;
      logic                 last;
   } mid_word_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          last;
   } out_word_type;

   typedef logic [SAMPLE_BITS-1:0] rom_word_type;
   typedef rom_word_type sine_rom_type [0:QTR_SIZE];

   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      logic [63:0]  x;
      logic [63:0]  x2;
      logic [63:0]  term;
      logic [63:0]  rounded;
      longint       sum;
      for (int k = 0; k <= QTR_SIZE; k++) begin
         x    = (HALF_PI_Q30 * 64'(k) + 64'(QTR_HALF)) >> SINE_INDEX_BITS;
         x2   = (x * x) >> 30;
         term = x;
         sum  = longint'(x);
         for (int n = 1; n <= 10; n++) begin
            term = ((term * x2) >> 30) / 64'(TAYLOR_DIV[n]);
            if (n[0]) begin
               sum = sum - longint'(term);
            end else begin
               sum = sum + longint'(term);
            end
         end
         if (sum < 0) begin
            sum = 0;
         end
         rounded = (64'(sum) + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
         rom[k]  = rounded[SAMPLE_BITS-1:0];
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine_rom();

endpackage

@@ hdl/mstg_front.sv @@
// Front end: configuration registers, phase accumulator and tone length counter.
module mstg_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [mstg_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [mstg_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   input  logic                              req_push,
   input  logic                              req_start_req,
   output logic                              req_full,
   input  mstg_pkg::queue_status_type        mid_status,
   output logic                              mid_push,
   output mstg_pkg::mid_word_type            mid_word
);
   import mstg_pkg::*;

   shape_type                shape_ff, shape_in;
   logic [STEP_BITS-1:0]     step_ff, step_in;
   logic [PEAK_BITS-1:0]     peak_ff, peak_in;
   logic [LENGTH_BITS-1:0]   length_ff, length_in;
   logic [PHASE_BITS-1:0]    phase_ff, phase_in;
   logic [COUNT_BITS-1:0]    left_ff, left_in;

   logic                             accept;
   logic [PHASE_BITS-1:0]            start_phase;
   logic [COUNT_BITS-1:0]            start_left;
   logic [COUNT_BITS-1:0]            load_left;
   logic [LEN_CMP_BITS-1:0]          len_wide;
   logic [PHASE_BITS+PTOP_BITS-1:0]  phase_pad;

   always_comb begin
      shape_in  = shape_ff;
      step_in   = step_ff;
      peak_in   = peak_ff;
      length_in = length_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_WAVE_SHAPE:  shape_in  = shape_type'(csr_wdata[SHAPE_BITS-1:0]);
            CSR_PHASE_STEP:  step_in   = csr_wdata[STEP_BITS-1:0];
            CSR_PEAK_LEVEL:  peak_in   = csr_wdata[PEAK_BITS-1:0];
            CSR_TONE_LENGTH: length_in = csr_wdata[LENGTH_BITS-1:0];
         endcase
      end
   end

   always_comb begin
      req_full    = mid_status.full;
      accept      = req_push && !mid_status.full;
      len_wide    = LEN_CMP_BITS'(length_ff);
      load_left   = (len_wide > LEN_CMP_BITS'(COUNT_MAX)) ? COUNT_MAX
                                                           : COUNT_BITS'(len_wide);
      start_phase = req_start_req ? '0 : phase_ff;
      start_left  = req_start_req ? load_left : left_ff;
      phase_pad   = {start_phase, {PTOP_BITS{1'b0}}};

      mid_push       = accept && (start_left != '0);
      mid_word.ptop  = phase_pad[PHASE_BITS+PTOP_BITS-1 -: PTOP_BITS];
      mid_word.shape = shape_ff;
      mid_word.peak  = peak_ff;
      mid_word.last  = (start_left == COUNT_BITS'(1));

      phase_in = phase_ff;
      left_in  = left_ff;
      if (accept) begin
         phase_in = start_phase;
         left_in  = start_left;
         if (start_left != '0) begin
            left_in  = start_left - COUNT_BITS'(1);
            phase_in = start_phase + PHASE_BITS'(step_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shape_ff  <= SHAPE_SINE;
         step_ff   <= RESET_PHASE_STEP;
         peak_ff   <= RESET_PEAK_LEVEL;
         length_ff <= RESET_TONE_LENGTH;
         phase_ff  <= '0;
         left_ff   <= '0;
      end else begin
         shape_ff  <= shape_in;
         step_ff   <= step_in;
         peak_ff   <= peak_in;
         length_ff <= length_in;
         phase_ff  <= phase_in;
         left_ff   <= left_in;
      end
   end

endmodule

@@ hdl/mstg_queue.sv @@
// Short queue of classified words between the front end and the sample pipeline.
module mstg_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  mstg_pkg::mid_word_type     push_word,
   input  logic                       pop,
   output mstg_pkg::mid_word_type     pop_word,
   output mstg_pkg::queue_status_type status
);
   import mstg_pkg::*;

   mid_word_type          mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]  count_ff, count_in;

   always_comb begin
      status.full  = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
      status.empty = (count_ff == '0);
      pop_word     = mem_ff[rd_ptr_ff];
      wr_ptr_in    = push ? wr_ptr_ff + QPTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in    = pop ? rd_ptr_ff + QPTR_BITS'(1) : rd_ptr_ff;
      count_in     = count_ff + QCNT_BITS'(push) - QCNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ hdl/mstg_back.sv @@
// Sample pipeline: waveform lookup, peak scaling, saturation and the result queue.
module mstg_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  mstg_pkg::queue_status_type            mid_status,
   input  mstg_pkg::mid_word_type                mid_word,
   output logic                                  mid_pop,
   input  logic                                  rsp_pop,
   output logic                                  rsp_empty,
   output logic signed [mstg_pkg::SAMPLE_BITS-1:0] rsp_sample,
   output logic                                  rsp_last
);
   import mstg_pkg::*;

   logic                      s1_valid_ff, s1_valid_in;
   shape_type                 s1_shape_ff;
   logic                      s1_neg_ff, s1_neg_in;
   logic [SAMPLE_BITS-1:0]    s1_mag_ff, s1_mag_in;
   logic [PEAK_BITS-1:0]      s1_peak_ff;
   logic                      s1_last_ff;
   logic [SAMPLE_BITS-1:0]    rom_data_ff;
   logic [ROM_ADDR_BITS-1:0]  rom_addr;

   logic                      s2_valid_ff;
   logic                      s2_neg_ff;
   logic                      s2_last_ff;
   logic [PROD_BITS-1:0]      s2_prod_ff, s2_prod_in;
   logic [SAMPLE_BITS-1:0]    mag_sel;

   out_word_type              out_mem_ff [QUEUE_DEPTH];
   out_word_type              out_word;
   logic [QPTR_BITS-1:0]      out_wr_ptr_ff, out_wr_ptr_in;
   logic [QPTR_BITS-1:0]      out_rd_ptr_ff, out_rd_ptr_in;
   logic [QCNT_BITS-1:0]      out_count_ff, out_count_in;
   logic                      out_pop;
   logic [QCNT_BITS:0]        occupancy;

   logic [SINE_TOP_BITS-1:0]  sine_u;
   logic [1:0]                quad;
   logic [TRI_BITS-1:0]       tri_u;
   logic [TRI_BITS-1:0]       tri_diff;
   logic [SAMPLE_BITS-1:0]    saw_u;
   logic [MAG_BITS-1:0]       scaled;

   // Results in flight are counted against free places in the result queue.
   always_comb begin
      occupancy = (QCNT_BITS+1)'(out_count_ff) + (QCNT_BITS+1)'(s1_valid_ff)
                + (QCNT_BITS+1)'(s2_valid_ff);
      mid_pop     = !mid_status.empty && (occupancy < (QCNT_BITS+1)'(QUEUE_DEPTH));
      s1_valid_in = mid_pop;
   end

   always_comb begin
      sine_u   = mid_word.ptop[PTOP_BITS-1 -: SINE_TOP_BITS];
      quad     = sine_u[SINE_TOP_BITS-1 -: 2];
      rom_addr = quad[0] ? ROM_ADDR_BITS'(QTR_SIZE) - {1'b0, sine_u[SINE_INDEX_BITS-1:0]}
                         : {1'b0, sine_u[SINE_INDEX_BITS-1:0]};
      tri_u    = mid_word.ptop[PTOP_BITS-1 -: TRI_BITS];
      saw_u    = mid_word.ptop[PTOP_BITS-1 -: SAMPLE_BITS];
      tri_diff = '0;
      s1_neg_in = 1'b0;
      s1_mag_in = '0;
      unique case (mid_word.shape)
         SHAPE_SINE: begin
            s1_neg_in = quad[1];
         end
         SHAPE_TRIANGLE: begin
            if (!tri_u[TRI_BITS-1]) begin
               s1_neg_in = (tri_u < TRI_ONE);
               tri_diff  = s1_neg_in ? TRI_ONE - tri_u : tri_u - TRI_ONE;
            end else begin
               s1_neg_in = (tri_u > TRI_THREE);
               tri_diff  = s1_neg_in ? tri_u - TRI_THREE : TRI_THREE - tri_u;
            end
            s1_mag_in = tri_diff[SAMPLE_BITS-1:0];
         end
         SHAPE_SAWTOOTH: begin
            s1_neg_in = !saw_u[SAMPLE_BITS-1];
            s1_mag_in = s1_neg_in ? WAVE_ONE - saw_u : saw_u - WAVE_ONE;
         end
         SHAPE_SQUARE: begin
            s1_neg_in = !mid_word.ptop[PTOP_BITS-1];
            s1_mag_in = WAVE_ONE;
         end
      endcase
   end

   always_comb begin
      mag_sel    = (s1_shape_ff == SHAPE_SINE) ? rom_data_ff : s1_mag_ff;
      s2_prod_in = PROD_BITS'(mag_sel) * PROD_BITS'(s1_peak_ff);
   end

   always_comb begin
      scaled        = s2_prod_ff[PROD_BITS-1:FRAC_BITS];
      out_word.last = s2_last_ff;
      if (s2_neg_ff) begin
         if (scaled > MAG_BITS'(WAVE_ONE)) begin
            out_word.sample = WAVE_ONE;
         end else begin
            out_word.sample = -(SAMPLE_BITS'(scaled));
         end
      end else begin
         if (scaled > MAG_BITS'(SAT_POS)) begin
            out_word.sample = SAT_POS;
         end else begin
            out_word.sample = SAMPLE_BITS'(scaled);
         end
      end
   end

   always_comb begin
      rsp_empty     = (out_count_ff == '0);
      rsp_sample    = out_mem_ff[out_rd_ptr_ff].sample;
      rsp_last      = out_mem_ff[out_rd_ptr_ff].last;
      out_pop       = rsp_pop && !rsp_empty;
      out_wr_ptr_in = s2_valid_ff ? out_wr_ptr_ff + QPTR_BITS'(1) : out_wr_ptr_ff;
      out_rd_ptr_in = out_pop ? out_rd_ptr_ff + QPTR_BITS'(1) : out_rd_ptr_ff;
      out_count_in  = out_count_ff + QCNT_BITS'(s2_valid_ff) - QCNT_BITS'(out_pop);
   end

   always_ff @(posedge clock) begin
      rom_data_ff <= SINE_ROM[rom_addr];
      s1_shape_ff <= mid_word.shape;
      s1_neg_ff   <= s1_neg_in;
      s1_mag_ff   <= s1_mag_in;
      s1_peak_ff  <= mid_word.peak;
      s1_last_ff  <= mid_word.last;
      s2_neg_ff   <= s1_neg_ff;
      s2_last_ff  <= s1_last_ff;
      s2_prod_ff  <= s2_prod_in;
      if (s2_valid_ff) begin
         out_mem_ff[out_wr_ptr_ff] <= out_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         out_wr_ptr_ff <= '0;
         out_rd_ptr_ff <= '0;
         out_count_ff  <= '0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         s2_valid_ff   <= s1_valid_ff;
         out_wr_ptr_ff <= out_wr_ptr_in;
         out_rd_ptr_ff <= out_rd_ptr_in;
         out_count_ff  <= out_count_in;
      end
   end

endmodule

@@ hdl/multi_shape_tone_generator_unit.sv @@
// Top level of the multi-shape tone generator: front end, word queue and sample pipeline.
//
//   Channel   Direction  Handshake                 Word
//   req_      in         push / full               start_req
//   rsp_      out        empty / pop               sample, last
//   csr_      in         we (no wait)              index, wdata
//
// One word is accepted per cycle while full is low; a sample then passes the word queue,
// the registered sine table read, the registered peak multiply and the result queue.
// Synchronous reset clears the phase, tone counter and queues and loads default settings.
// When the result queue backs up, the word queue fills and full rises toward the source.
module multi_shape_tone_generator_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [mstg_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [mstg_pkg::CSR_DATA_BITS-1:0]      csr_wdata,
   input  logic                                  req_push,
   output logic                                  req_full,
   input  logic                                  req_start_req,
   input  logic                                  rsp_pop,
   output logic                                  rsp_empty,
   output logic signed [mstg_pkg::SAMPLE_BITS-1:0] rsp_sample,
   output logic                                  rsp_last
);
   import mstg_pkg::*;

   queue_status_type mid_status;
   mid_word_type     mid_push_word;
   mid_word_type     mid_pop_word;
   logic             mid_push;
   logic             mid_pop;

   mstg_front u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_push      (req_push),
      .req_start_req (req_start_req),
      .req_full      (req_full),
      .mid_status    (mid_status),
      .mid_push      (mid_push),
      .mid_word      (mid_push_word)
   );

   mstg_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_push),
      .push_word (mid_push_word),
      .pop       (mid_pop),
      .pop_word  (mid_pop_word),
      .status    (mid_status)
   );

   mstg_back u_back (
      .clock      (clock),
      .reset      (reset),
      .mid_status (mid_status),
      .mid_word   (mid_pop_word),
      .mid_pop    (mid_pop),
      .rsp_pop    (rsp_pop),
      .rsp_empty  (rsp_empty),
      .rsp_sample (rsp_sample),
      .rsp_last   (rsp_last)
   );

   a_reset_clears : assert property (@(posedge clock) reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

   a_no_push_full : assert property (@(posedge clock) disable iff (reset)
      mid_status.full |-> !mid_push)
      else $error("word pushed into full queue");

   a_no_pop_empty : assert property (@(posedge clock) disable iff (reset)
      mid_status.empty |-> !mid_pop)
      else $error("word popped from empty queue");

endmodule

@@ test/tone_sample_checker.sv @@
// Checker that predicts every tone sample from the accepted words and compares the popped ones.
module tone_sample_checker (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_we,
   input  logic [mstg_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [mstg_pkg::CSR_DATA_BITS-1:0]      csr_wdata,
   input  logic                                    req_push,
   input  logic                                    req_full,
   input  logic                                    req_start_req,
   input  logic                                    rsp_pop,
   input  logic                                    rsp_empty,
   input  logic signed [mstg_pkg::SAMPLE_BITS-1:0] rsp_sample,
   input  logic                                    rsp_last,
   output int                                      error_count,
   output int                                      pending_samples,
   output int                                      checked_samples
);
   import mstg_pkg::*;

   localparam longint FULL_SCALE = longint'(1) << FRAC_BITS;
   localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          last;
   } tone_sample_type;

   int                      quarter_sine [0:QTR_SIZE];
   tone_sample_type         expected_samples [$];

   shape_type               shape_reg;
   logic [STEP_BITS-1:0]    step_reg;
   logic [PEAK_BITS-1:0]    peak_reg;
   logic [LENGTH_BITS-1:0]  length_reg;
   logic [PHASE_BITS-1:0]   phase_acc;
   logic [COUNT_BITS-1:0]   samples_left;

   initial begin : build_quarter_sine
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      longint      acc;
      for (int k = 0; k <= QTR_SIZE; k++) begin
         x    = (QUARTER_TURN_Q30 * 64'(k) + 64'(QTR_SIZE / 2)) >> SINE_INDEX_BITS;
         x2   = (x * x) >> 30;
         term = x;
         acc  = longint'(x);
         for (int n = 1; n <= 10; n++) begin
            term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            acc  = (n % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
         end
         if (acc < 0) begin
            acc = 0;
         end
         quarter_sine[k] = int'((acc + (longint'(1) << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS));
      end
   end

   function automatic logic signed [SAMPLE_BITS-1:0] predict_sample(
      input logic [PHASE_BITS-1:0] phase
   );
      logic [SINE_TOP_BITS-1:0] sine_top;
      longint                   ramp;
      longint                   wave;
      longint                   magnitude;
      longint                   scaled;
      sine_top = phase[PHASE_BITS-1 -: SINE_TOP_BITS];
      case (shape_reg)
         SHAPE_SINE: begin
            if (sine_top[SINE_INDEX_BITS]) begin
               wave = quarter_sine[QTR_SIZE - int'(sine_top[SINE_INDEX_BITS-1:0])];
            end else begin
               wave = quarter_sine[int'(sine_top[SINE_INDEX_BITS-1:0])];
            end
            if (sine_top[SINE_INDEX_BITS+1]) begin
               wave = -wave;
            end
         end
         SHAPE_TRIANGLE: begin
            ramp = longint'(phase[PHASE_BITS-1 -: SAMPLE_BITS+1]);
            wave = (ramp < 2 * FULL_SCALE) ? ramp - FULL_SCALE : 3 * FULL_SCALE - ramp;
         end
         SHAPE_SAWTOOTH: begin
            wave = longint'(phase[PHASE_BITS-1 -: SAMPLE_BITS]) - FULL_SCALE;
         end
         default: begin
            wave = phase[PHASE_BITS-1] ? FULL_SCALE : -FULL_SCALE;
         end
      endcase
      magnitude = ((wave < 0 ? -wave : wave) * longint'(peak_reg)) >>> FRAC_BITS;
      scaled    = (wave < 0) ? -magnitude : magnitude;
      if (scaled > FULL_SCALE - 1) begin
         scaled = FULL_SCALE - 1;
      end
      if (scaled < -FULL_SCALE) begin
         scaled = -FULL_SCALE;
      end
      return scaled[SAMPLE_BITS-1:0];
   endfunction

   always @(posedge clock) begin
      tone_sample_type got;
      tone_sample_type want;
      if (reset) begin
         shape_reg    = SHAPE_SINE;
         step_reg     = RESET_PHASE_STEP;
         peak_reg     = RESET_PEAK_LEVEL;
         length_reg   = RESET_TONE_LENGTH;
         phase_acc    = '0;
         samples_left = '0;
         expected_samples.delete();
         error_count     <= 0;
         checked_samples <= 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            got.sample = rsp_sample;
            got.last   = rsp_last;
            if (expected_samples.size() == 0) begin
               if (error_count < 10) begin
                  $display("ERROR: word sample=%0d last=%0b popped with nothing expected",
                           got.sample, got.last);
               end
               error_count <= error_count + 1;
            end else begin
               want = expected_samples.pop_front();
               if (got.sample !== want.sample || got.last !== want.last) begin
                  if (error_count < 10) begin
                     $display("ERROR: word %0d: sample expected %0d got %0d, last expected %0b got %0b",
                              checked_samples, want.sample, got.sample, want.last, got.last);
                  end
                  error_count <= error_count + 1;
               end
            end
            checked_samples <= checked_samples + 1;
         end
         if (req_push && !req_full) begin
            if (req_start_req) begin
               phase_acc    = '0;
               samples_left = COUNT_BITS'(length_reg);
            end
            if (samples_left != 0) begin
               want.sample  = predict_sample(phase_acc);
               want.last    = (samples_left == 1);
               expected_samples.push_back(want);
               samples_left = samples_left - 1'b1;
               phase_acc    = phase_acc + step_reg;
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_WAVE_SHAPE:  shape_reg  = shape_type'(csr_wdata[SHAPE_BITS-1:0]);
               CSR_PHASE_STEP:  step_reg   = csr_wdata[STEP_BITS-1:0];
               CSR_PEAK_LEVEL:  peak_reg   = csr_wdata[PEAK_BITS-1:0];
               CSR_TONE_LENGTH: length_reg = csr_wdata[LENGTH_BITS-1:0];
               default: ;
            endcase
         end
      end
      pending_samples <= expected_samples.size();
   end

endmodule

@@ test/multi_shape_tone_generator_unit_tb.sv @@
// Testbench top for the tone generator: clock, reset, word stimulus, register settings and verdict.
module multi_shape_tone_generator_unit_tb;
   import mstg_pkg::*;

   localparam int CYCLE_LIMIT = 500000;
   localparam int RANDOM_SETTINGS = 12;
   localparam int WORDS_PER_SETTING = 125;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          csr_we = 1'b0;
   csr_index_type                 csr_index = CSR_WAVE_SHAPE;
   logic [CSR_DATA_BITS-1:0]      csr_wdata = '0;
   logic                          req_push = 1'b0;
   logic                          req_full;
   logic                          req_start_req = 1'b0;
   logic                          rsp_pop = 1'b0;
   logic                          rsp_empty;
   logic signed [SAMPLE_BITS-1:0] rsp_sample;
   logic                          rsp_last;

   int error_count;
   int pending_samples;
   int checked_samples;

   int cycle_count = 0;
   int hold_ask = 0;
   int hold_seen = 0;
   int burst_left = 0;
   int words_sent = 0;
   int sample_words = 0;
   int settings_used = 0;
   logic [LENGTH_BITS-1:0] tone_len = RESET_TONE_LENGTH;
   logic [LENGTH_BITS-1:0] tone_remaining = '0;

   multi_shape_tone_generator_unit dut (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_start_req (req_start_req),
      .rsp_pop       (rsp_pop),
      .rsp_empty     (rsp_empty),
      .rsp_sample    (rsp_sample),
      .rsp_last      (rsp_last)
   );

   tone_sample_checker sample_checker (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_start_req   (req_start_req),
      .rsp_pop         (rsp_pop),
      .rsp_empty       (rsp_empty),
      .rsp_sample      (rsp_sample),
      .rsp_last        (rsp_last),
      .error_count     (error_count),
      .pending_samples (pending_samples),
      .checked_samples (checked_samples)
   );

   always #5 clock = ~clock;

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("ERROR: run did not finish within %0d cycles", CYCLE_LIMIT);
      $display("Simulation FAILED");
      $finish;
   end

   initial begin : receiver
      int seg_left;
      int mode;
      seg_left = 0;
      mode     = 0;
      forever begin
         @(negedge clock);
         if (hold_seen != hold_ask) begin
            rsp_pop <= 1'b0;
            repeat (300) @(negedge clock);
            hold_seen = hold_ask;
         end else begin
            if (seg_left == 0) begin
               mode     = $urandom_range(0, 3);
               seg_left = $urandom_range(5, 60);
            end
            seg_left--;
            case (mode)
               0:       rsp_pop <= 1'b1;
               1:       rsp_pop <= 1'($urandom_range(0, 1));
               2:       rsp_pop <= ($urandom_range(0, 7) == 0);
               default: rsp_pop <= ~rsp_pop;
            endcase
         end
      end
   end

   task automatic offer_word(input logic start);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         repeat (gap) begin
            @(negedge clock);
            req_push      <= 1'b0;
            req_start_req <= 1'($urandom_range(0, 1));
         end
      end
      burst_left--;
      @(negedge clock);
      req_push      <= 1'b1;
      req_start_req <= start;
      @(posedge clock);
      while (req_full) begin
         @(posedge clock);
      end
      words_sent++;
      if (start) begin
         tone_remaining = tone_len;
      end
      if (tone_remaining != 0) begin
         tone_remaining = tone_remaining - 1'b1;
         sample_words++;
      end
   endtask

   task automatic wait_for_quiet();
      @(negedge clock);
      req_push <= 1'b0;
      @(posedge clock);
      while (pending_samples != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [CSR_DATA_BITS-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      if (idx == CSR_TONE_LENGTH) begin
         tone_len = value[LENGTH_BITS-1:0];
      end
   endtask

   task automatic apply_setting(input shape_type shape, input logic [STEP_BITS-1:0] step,
                                input logic [PEAK_BITS-1:0] peak,
                                input logic [LENGTH_BITS-1:0] length);
      logic [CSR_DATA_BITS-1:0] wdata;
      wdata = $urandom();
      wdata[SHAPE_BITS-1:0] = shape;
      write_register(CSR_WAVE_SHAPE, wdata);
      write_register(CSR_PHASE_STEP, step);
      wdata = $urandom();
      wdata[PEAK_BITS-1:0] = peak;
      write_register(CSR_PEAK_LEVEL, wdata);
      wdata = $urandom();
      wdata[LENGTH_BITS-1:0] = length;
      write_register(CSR_TONE_LENGTH, wdata);
      settings_used++;
   endtask

   initial begin : stimulus
      logic [STEP_BITS-1:0]   step;
      logic [PEAK_BITS-1:0]   peak;
      logic [LENGTH_BITS-1:0] length;
      int                     setting_base;
      int                     tones;
      int                     follow_words;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: a word with no tone running, then the start of a sine tone.
      offer_word(1'b0);
      offer_word(1'b1);
      repeat (2) offer_word(1'b0);

      // Full-scale square: both saturation limits and the final-sample flag.
      wait_for_quiet();
      apply_setting(SHAPE_SQUARE, 32'h8000_0000, 16'd32768, 24'd3);
      offer_word(1'b1);
      repeat (3) offer_word(1'b0);

      // Peak above range on a triangle, longest tone, restart in the middle.
      wait_for_quiet();
      apply_setting(SHAPE_TRIANGLE, 32'h4000_0000, 16'hFFFF, 24'hFF_FFFF);
      offer_word(1'b1);
      repeat (4) offer_word(1'b0);
      offer_word(1'b1);
      offer_word(1'b0);

      // A start with zero length yields nothing.
      wait_for_quiet();
      apply_setting(SHAPE_SAWTOOTH, 32'hFFFF_FFFF, 16'd0, 24'd0);
      offer_word(1'b1);
      offer_word(1'b0);

      // Sine from zero up to its peak at the start of the second quadrant, at full scale.
      wait_for_quiet();
      apply_setting(SHAPE_SINE, 32'h1000_0000, 16'd32768, 24'd5);
      offer_word(1'b1);
      repeat (4) offer_word(1'b0);

      for (int setting = 0; setting < RANDOM_SETTINGS; setting++) begin
         wait_for_quiet();
         case ($urandom_range(0, 7))
            0:       step = '0;
            1:       step = '1;
            2:       step = $urandom_range(1, 1 << 20);
            default: step = $urandom();
         endcase
         case ($urandom_range(0, 5))
            0:       peak = '0;
            1:       peak = 16'd32768;
            2:       peak = '1;
            3:       peak = PEAK_BITS'($urandom_range(0, 65535));
            default: peak = PEAK_BITS'($urandom_range(0, 32768));
         endcase
         case ($urandom_range(0, 9))
            0:       length = '0;
            1:       length = '1;
            2:       length = LENGTH_BITS'($urandom());
            3:       length = 24'd1;
            default: length = LENGTH_BITS'($urandom_range(2, 40));
         endcase
         apply_setting(shape_type'($urandom_range(0, 3)), step, peak, length);
         if (tone_len != '0 && ((hold_ask == 0 && setting >= 2) ||
                                (hold_ask == 1 && setting >= 8))) begin
            hold_ask++;
         end
         setting_base = words_sent;
         tones = 0;
         while (words_sent - setting_base < WORDS_PER_SETTING && tones < 60) begin
            tones++;
            if (tone_len != 0 && tone_len <= 64) begin
               follow_words = int'(tone_len) - 1 + $urandom_range(0, 2);
            end else begin
               follow_words = $urandom_range(0, 40);
            end
            offer_word(1'b1);
            repeat (follow_words) offer_word($urandom_range(0, 29) == 0);
         end
      end
      wait_for_quiet();

      $display("Run covered %0d words offered, %0d samples expected and %0d checked over %0d register settings.",
               words_sent, sample_words, checked_samples, settings_used);
      $display("All four wave shapes, saturation at both ends, zero and maximum tone lengths.");
      if (pending_samples != 0) begin
         $display("ERROR: %0d expected samples never arrived", pending_samples);
      end
      if (error_count == 0 && pending_samples == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

@@ multi_shape_tone_generator_unit.f @@
hdl/mstg_pkg.sv
hdl/mstg_front.sv
hdl/mstg_queue.sv
hdl/mstg_back.sv
hdl/multi_shape_tone_generator_unit.sv
test/tone_sample_checker.sv
test/multi_shape_tone_generator_unit_tb.sv
